@@ rtl/rssi_window_min_average_alarm_top_macros.svh @@
// assertion helpers shared by the ring, tone and output queue rtl files
// each one expects clk and arst_n in scope and is off while reset is low
`ifndef RSSI_WINDOW_MIN_AVERAGE_ALARM_TOP_MACROS_SVH
`define RSSI_WINDOW_MIN_AVERAGE_ALARM_TOP_MACROS_SVH

// property that must hold at every clock edge
`define RWMA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked in the same cycle
`define RWMA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ rtl/rwma_pkg.sv @@
`default_nettype none

package rwma_pkg;

	localparam int RING_DEPTH_DEF  = 8;
	localparam int SAMPLE_BITS_DEF = 10;

	localparam int THR_BITS       = 10;
	localparam int COUNT_BITS     = 10;
	localparam int TONE_BITS      = 8;
	localparam int PULSE_BITS     = 12;
	localparam int DUTY_BITS      = 8;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 12;

	localparam logic [THR_BITS-1:0]   LOW_THR_RST    = 10'd120;
	localparam logic [THR_BITS-1:0]   NOSIG_THR_RST  = 10'd180;
	localparam logic [COUNT_BITS-1:0] WINDOW_END_RST = 10'd200;
	localparam logic [TONE_BITS-1:0]  TONE_DIV_RST   = 8'd3;
	localparam logic [PULSE_BITS-1:0] PULSE_PER_RST  = 12'd1500;
	localparam logic [DUTY_BITS-1:0]  DUTY_MAX       = 8'd255;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_LOW_THR    = 3'd0,
		REG_NOSIG_THR  = 3'd1,
		REG_WINDOW_END = 3'd2,
		REG_TONE_DIV   = 3'd3,
		REG_PULSE_PER  = 3'd4
	} reg_index_t;

	typedef enum logic [1:0] {
		MODE_NONE  = 2'd0,
		MODE_CONT  = 2'd1,
		MODE_PULSE = 2'd2
	} mode_t;

	// outcome of a window close, from the ring to the tone logic
	typedef struct packed {
		logic                 close;
		logic                 alarm_on;
		logic                 pulsed;
		logic [DUTY_BITS-1:0] duty;
	} verdict_t;

	// one result item
	typedef struct packed {
		logic                 alarm;
		logic                 tone;
		mode_t                mode;
		logic [DUTY_BITS-1:0] duty;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/rssi_window_min_average_alarm_top.sv @@
// signal-strength alarm: takes one converter sample per request, tracks the
// minimum over each window of window_end+1 samples, keeps the last RING_DEPTH
// window minima in a ring memory and averages them through a running sum;
// the average drives the alarm pin, the alarm mode (continuous or pulsed
// tone), the tone pin and a pwm duty of 255 minus the saturated average.
// one sample is accepted every clock while the skid is empty, and its result
// is registered in the output stage; the rate is set by the ring memory, which
// has one write and one registered read port: the entry to be replaced is
// always prefetched at the write pointer (one ahead right after a close), so
// a window may close on every sample. ring entries start at zero through
// per-entry valid bits cleared by reset, so there is no clearing pass after
// reset. a two-deep output stage (register plus skid) lets samples keep
// coming while a result waits. configuration writes take effect at the next
// edge and are meant to happen only while no sample is in flight.
`default_nettype none

module rssi_window_min_average_alarm_top #(
	parameter int RING_DEPTH  = rwma_pkg::RING_DEPTH_DEF,
	parameter int SAMPLE_BITS = rwma_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// sample request
	input  logic                                sample_valid,
	output logic                                sample_ready,
	input  logic [SAMPLE_BITS-1:0]              sample,
	// result request
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic                                alarm_out,
	output logic                                tone_out,
	output logic [1:0]                          alarm_mode,
	output logic [rwma_pkg::DUTY_BITS-1:0]      duty,
	// register write port
	input  logic                                cfg_we,
	input  logic [rwma_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [rwma_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import rwma_pkg::*;

	// configuration
	logic [THR_BITS-1:0]   low_thr_q;
	logic [THR_BITS-1:0]   nosig_thr_q;
	logic [COUNT_BITS-1:0] window_end_q;
	logic [TONE_BITS-1:0]  tone_div_q;
	logic [PULSE_BITS-1:0] pulse_per_q;

	// window tracking
	logic [SAMPLE_BITS:0]   win_min_q;
	logic [SAMPLE_BITS:0]   min_next;
	logic [COUNT_BITS-1:0]  count_q;
	logic                   accept;
	logic                   close;

	verdict_t verdict;
	result_t  result_next;
	result_t  result_q;

	assign accept = sample_valid && sample_ready;
	// window closes on the sample that finds the old count at window_end
	assign close  = accept && (count_q == window_end_q);

	// the current sample is part of the window it may close
	assign min_next = ({1'b0, sample} < win_min_q) ? {1'b0, sample} : win_min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_thr_q    <= LOW_THR_RST;
			nosig_thr_q  <= NOSIG_THR_RST;
			window_end_q <= WINDOW_END_RST;
			tone_div_q   <= TONE_DIV_RST;
			pulse_per_q  <= PULSE_PER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOW_THR:    low_thr_q    <= cfg_data[THR_BITS-1:0];
				REG_NOSIG_THR:  nosig_thr_q  <= cfg_data[THR_BITS-1:0];
				REG_WINDOW_END: window_end_q <= cfg_data[COUNT_BITS-1:0];
				REG_TONE_DIV:   tone_div_q   <= cfg_data[TONE_BITS-1:0];
				REG_PULSE_PER:  pulse_per_q  <= cfg_data[PULSE_BITS-1:0];
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// empty window holds a minimum above any sample
			win_min_q <= {1'b1, {SAMPLE_BITS{1'b0}}};
			count_q   <= '0;
		end else if (accept) begin
			if (close) begin
				win_min_q <= {1'b1, {SAMPLE_BITS{1'b0}}};
				count_q   <= '0;
			end else begin
				win_min_q <= min_next;
				count_q   <= count_q + 1'b1;
			end
		end
	end

	// ring memory, running sum and alarm decision
	rwma_ring #(
		.RING_DEPTH  (RING_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.close     (close),
		.min_value (min_next[SAMPLE_BITS-1:0]),
		.low_thr   (low_thr_q),
		.nosig_thr (nosig_thr_q),
		.verdict   (verdict)
	);

	// tone divider, pulse gating and pin state
	rwma_tone u_tone (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.verdict   (verdict),
		.tone_div  (tone_div_q),
		.pulse_per (pulse_per_q),
		.result    (result_next)
	);

	// output register with skid
	rwma_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_data  (result_next),
		.push_ready (sample_ready),
		.pop_valid  (result_valid),
		.pop_ready  (result_ready),
		.pop_data   (result_q)
	);

	assign alarm_out  = result_q.alarm;
	assign tone_out   = result_q.tone;
	assign alarm_mode = result_q.mode;
	assign duty       = result_q.duty;

endmodule

`default_nettype wire

@@ rtl/rwma_ring.sv @@
`default_nettype none
`include "rssi_window_min_average_alarm_top_macros.svh"

module rwma_ring #(
	parameter int RING_DEPTH  = rwma_pkg::RING_DEPTH_DEF,
	parameter int SAMPLE_BITS = rwma_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          close,
	input  logic [SAMPLE_BITS-1:0]        min_value,
	input  logic [rwma_pkg::THR_BITS-1:0] low_thr,
	input  logic [rwma_pkg::THR_BITS-1:0] nosig_thr,
	output rwma_pkg::verdict_t            verdict
);
	import rwma_pkg::*;

	localparam int IdxW   = $clog2(RING_DEPTH);
	localparam int SumW   = SAMPLE_BITS + IdxW;
	localparam int LimW   = THR_BITS + 1 + IdxW;
	localparam int CmpW   = (SumW > LimW) ? SumW : LimW;
	localparam int DivN   = DUTY_BITS + IdxW;
	localparam int DivS   = DivN + IdxW;
	localparam int RecipM = ((1 << DivS) + RING_DEPTH - 1) / RING_DEPTH;
	localparam logic [IdxW-1:0] LastIdx = IdxW'(RING_DEPTH - 1);
	localparam logic [SumW:0]   SatLim  = (SumW + 1)'((1 << DUTY_BITS) * RING_DEPTH);
	localparam logic [DivN:0]   Recip   = (DivN + 1)'(RecipM);

	logic [SAMPLE_BITS-1:0] mem [RING_DEPTH];
	logic [RING_DEPTH-1:0]  valid_q;
	logic [IdxW-1:0]        idx_q;
	logic [IdxW-1:0]        idx_next;
	logic [IdxW-1:0]        rd_addr;
	logic [SAMPLE_BITS-1:0] rd_data_s1;
	logic                   rd_valid_s1;
	logic [SAMPLE_BITS-1:0] old_entry;
	logic [SumW-1:0]        sum_q;
	logic [SumW-1:0]        new_sum;
	logic [LimW-1:0]        low_lim;
	logic [LimW-1:0]        nosig_lim;
	logic [CmpW-1:0]        sum_cmp;
	logic                   sat;
	logic [DivN-1:0]        div_in;
	logic [2*DivN:0]        prod;
	logic [DUTY_BITS-1:0]   quot;

	assign idx_next = (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
	// keep the entry at the write pointer prefetched; after a close look one ahead
	assign rd_addr   = close ? idx_next : idx_q;
	assign old_entry = rd_valid_s1 ? rd_data_s1 : '0;
	assign new_sum   = sum_q - SumW'(old_entry) + SumW'(min_value);

	// average compares done on the sum against scaled thresholds
	assign low_lim   = LimW'({1'b0, low_thr} + 1'b1) * LimW'(RING_DEPTH);
	assign nosig_lim = LimW'(nosig_thr) * LimW'(RING_DEPTH);
	assign sum_cmp   = CmpW'(new_sum);

	// divide by depth through a reciprocal, exact below the saturation point
	assign sat    = {1'b0, new_sum} >= SatLim;
	assign div_in = new_sum[DivN-1:0];
	assign prod   = (2 * DivN + 1)'(div_in) * (2 * DivN + 1)'(Recip);
	assign quot   = prod[DivS +: DUTY_BITS];

	always_comb begin
		verdict.close    = close;
		verdict.alarm_on = sum_cmp >= CmpW'(low_lim);
		verdict.pulsed   = sum_cmp < CmpW'(nosig_lim);
		verdict.duty     = sat ? '0 : DUTY_MAX - quot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			sum_q       <= '0;
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= valid_q[rd_addr];
			if (close) begin
				idx_q          <= idx_next;
				sum_q          <= new_sum;
				valid_q[idx_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (close) begin
			mem[idx_q] <= min_value;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	`RWMA_ASSERT(a_prefetch_valid, rd_valid_s1 == valid_q[idx_q], "prefetch out of step")
	`RWMA_ASSERT_IMP(a_no_rw_collision, close, rd_addr != idx_q, "read hits write entry")

endmodule

`default_nettype wire

@@ rtl/rwma_tone.sv @@
`default_nettype none
`include "rssi_window_min_average_alarm_top_macros.svh"

module rwma_tone (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  rwma_pkg::verdict_t              verdict,
	input  logic [rwma_pkg::TONE_BITS-1:0]  tone_div,
	input  logic [rwma_pkg::PULSE_BITS-1:0] pulse_per,
	output rwma_pkg::result_t               result
);
	import rwma_pkg::*;

	mode_t                 mode_q, mode_d;
	logic [TONE_BITS-1:0]  tone_cnt_q, tone_cnt_d;
	logic [TONE_BITS-1:0]  tone_cnt_inc;
	logic [PULSE_BITS-1:0] pulse_cnt_q, pulse_cnt_d;
	logic                  phase_q, phase_d;
	logic                  tone_q, tone_d;
	logic                  alarm_q, alarm_d;
	logic [DUTY_BITS-1:0]  duty_q, duty_d;

	assign tone_cnt_inc = tone_cnt_q + 1'b1;

	always_comb begin
		mode_d      = mode_q;
		tone_cnt_d  = tone_cnt_q;
		pulse_cnt_d = pulse_cnt_q;
		phase_d     = phase_q;
		tone_d      = tone_q;
		alarm_d     = alarm_q;
		duty_d      = duty_q;
		// tone divider runs only while an alarm mode is set
		if (mode_q != MODE_NONE) begin
			tone_cnt_d = tone_cnt_inc;
			if (tone_cnt_inc == tone_div) begin
				tone_cnt_d = '0;
				if (mode_q == MODE_CONT || phase_q) begin
					tone_d = ~tone_q;
				end
				if (mode_q == MODE_PULSE) begin
					if (pulse_cnt_q == pulse_per) begin
						pulse_cnt_d = '0;
						phase_d     = ~phase_q;
						tone_d      = 1'b0;
					end else begin
						pulse_cnt_d = pulse_cnt_q + 1'b1;
					end
				end
			end
		end
		// window close overrides the alarm decision
		if (verdict.close) begin
			duty_d = verdict.duty;
			if (verdict.alarm_on) begin
				alarm_d = 1'b1;
				mode_d  = verdict.pulsed ? MODE_PULSE : MODE_CONT;
			end else begin
				mode_d  = MODE_NONE;
				tone_d  = 1'b0;
				alarm_d = 1'b0;
			end
		end
		result.alarm = alarm_d;
		result.tone  = tone_d;
		result.mode  = mode_d;
		result.duty  = duty_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_NONE;
			tone_cnt_q  <= '0;
			pulse_cnt_q <= '0;
			phase_q     <= 1'b0;
			tone_q      <= 1'b0;
			alarm_q     <= 1'b0;
			duty_q      <= '0;
		end else if (accept) begin
			mode_q      <= mode_d;
			tone_cnt_q  <= tone_cnt_d;
			pulse_cnt_q <= pulse_cnt_d;
			phase_q     <= phase_d;
			tone_q      <= tone_d;
			alarm_q     <= alarm_d;
			duty_q      <= duty_d;
		end
	end

	`RWMA_ASSERT(a_alarm_mode, alarm_q == (mode_q != MODE_NONE), "alarm pin and mode disagree")
	`RWMA_ASSERT_IMP(a_tone_needs_mode, tone_q, mode_q != MODE_NONE, "tone on with no alarm")

endmodule

`default_nettype wire

@@ rtl/rwma_outq.sv @@
`default_nettype none
`include "rssi_window_min_average_alarm_top_macros.svh"

module rwma_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rwma_pkg::result_t push_data,
	output logic              push_ready,
	output logic              pop_valid,
	input  logic              pop_ready,
	output rwma_pkg::result_t pop_data
);
	import rwma_pkg::*;

	result_t out_q;
	result_t skid_q;
	logic    out_valid_q;
	logic    skid_valid_q;
	logic    pop;

	assign push_ready = !skid_valid_q;
	assign pop_valid  = out_valid_q;
	assign pop_data   = out_q;
	assign pop        = out_valid_q && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			if (!out_valid_q) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			if (!out_valid_q) begin
				out_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

	`RWMA_ASSERT_IMP(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full with output empty")

endmodule

`default_nettype wire

@@ tb/sv/rssi_window_min_average_alarm_top_test.sv @@
`timescale 1ns / 100ps

module rssi_window_min_average_alarm_top_test;
	import rwma_pkg::*;

	// generous cycle budget, far above the slowest correct run
	localparam int CYCLE_LIMIT = 500000;

	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b0;
	logic                      sample_valid = 1'b0;
	logic                      sample_ready;
	logic [9:0]                sample       = '0;
	logic                      result_valid;
	logic                      result_ready = 1'b0;
	logic                      alarm_out;
	logic                      tone_out;
	logic [1:0]                alarm_mode;
	logic [DUTY_BITS-1:0]      duty;
	logic                      cfg_we       = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;

	rssi_window_min_average_alarm_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.alarm_out    (alarm_out),
		.tone_out     (tone_out),
		.alarm_mode   (alarm_mode),
		.duty         (duty),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 20 ns clock
	initial begin
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// alarm predictor: its own copy of the registers and of the block state
	// ------------------------------------------------------------------
	logic [9:0]  thr_low   = LOW_THR_RST;
	logic [9:0]  thr_nosig = NOSIG_THR_RST;
	logic [9:0]  win_last  = WINDOW_END_RST;
	logic [7:0]  tone_div  = TONE_DIV_RST;
	logic [11:0] pulse_len = PULSE_PER_RST;

	logic [10:0] cur_min      = 11'd1024;      // one above any sample
	logic [9:0]  win_count    = '0;
	logic [2:0]  slot         = '0;            // ring write pointer, wraps at 8
	logic [9:0]  minima [8]   = '{default: 10'd0};
	logic [12:0] minima_total = '0;
	mode_t       mode         = MODE_NONE;
	logic [7:0]  tick_count   = '0;
	logic        pulse_on     = 1'b0;
	logic [11:0] pulse_ticks  = '0;
	logic        tone         = 1'b0;
	logic        alarm        = 1'b0;
	logic [7:0]  duty_lvl     = '0;

	// results still owed by the block, oldest first
	result_t alarm_expected [$];

	int errors         = 0;
	int cycle_count    = 0;
	int send_idle_pct  = 0;
	int ready_idle_pct = 0;

	// level that the well-formed windows hover around
	int level  = 512;
	int spread = 8;

	// advance the predictor by one sample and return the result it owes
	function automatic result_t predict_alarm(input logic [9:0] s);
		result_t    r;
		logic [9:0] avg;
		logic [9:0] prev;
		if ({1'b0, s} < cur_min)
			cur_min = {1'b0, s};
		// tone divider only runs while an alarm mode is active
		if (mode != MODE_NONE) begin
			tick_count = tick_count + 8'd1;
			if (tick_count == tone_div) begin
				tick_count = '0;
				if (mode == MODE_CONT || pulse_on)
					tone = ~tone;
				if (mode == MODE_PULSE) begin
					if (pulse_ticks == pulse_len) begin
						pulse_ticks = '0;
						pulse_on    = ~pulse_on;
						tone        = 1'b0;
					end else begin
						pulse_ticks = pulse_ticks + 12'd1;
					end
				end
			end
		end
		prev      = win_count;
		win_count = win_count + 10'd1;
		// window close: replace oldest minimum, re-average, decide alarm
		if (prev == win_last) begin
			minima_total  = minima_total - {3'd0, minima[slot]} + {3'd0, cur_min[9:0]};
			minima[slot]  = cur_min[9:0];
			slot          = slot + 3'd1;
			avg           = minima_total[12:3];
			if (avg > thr_low) begin
				alarm = 1'b1;
				mode  = (avg < thr_nosig) ? MODE_PULSE : MODE_CONT;
			end else begin
				mode  = MODE_NONE;
				tone  = 1'b0;
				alarm = 1'b0;
			end
			duty_lvl  = (avg > 10'd255) ? 8'd0 : 8'd255 - avg[7:0];
			cur_min   = 11'd1024;
			win_count = '0;
		end
		r.alarm = alarm;
		r.tone  = tone;
		r.mode  = mode;
		r.duty  = duty_lvl;
		return r;
	endfunction

	function automatic int clamp_code(input int v);
		if (v < 0)
			return 0;
		if (v > 1023)
			return 1023;
		return v;
	endfunction

	// mostly windows of samples sitting just above a level near a threshold,
	// so the ring average actually crosses them; the rest is plain noise
	function automatic logic [9:0] pick_sample();
		if (win_count == '0 && $urandom_range(0, 5) == 0) begin
			case ($urandom_range(0, 2))
				0: level = clamp_code(int'(thr_low) + int'($urandom_range(0, 24)) - 12);
				1: level = clamp_code(int'(thr_nosig) + int'($urandom_range(0, 24)) - 12);
				default: level = $urandom_range(0, 1023);
			endcase
			spread = $urandom_range(0, 40);
		end
		if ($urandom_range(0, 99) < 12)
			return 10'($urandom_range(0, 1023));
		return 10'(clamp_code(level + int'($urandom_range(0, spread))));
	endfunction

	// ------------------------------------------------------------------
	// sample side
	// ------------------------------------------------------------------

	// one sample request; valid is only dropped when a gap is taken
	task automatic send_sample(input logic [9:0] value);
		if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct);
		end
		sample_valid <= 1'b1;
		sample       <= value;
		do
			@(posedge clk);
		while (!sample_ready);
		alarm_expected.push_back(predict_alarm(value));
	endtask

	// stop sending and wait for every owed result
	task automatic drain_results();
		sample_valid <= 1'b0;
		while (alarm_expected.size() != 0)
			@(posedge clk);
	endtask

	// one register write, mirrored into the predictor at the write edge
	task automatic cfg_write(input logic [2:0] idx, input logic [11:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_LOW_THR:    thr_low   = data[9:0];
			REG_NOSIG_THR:  thr_nosig = data[9:0];
			REG_WINDOW_END: win_last  = data[9:0];
			REG_TONE_DIV:   tone_div  = data[7:0];
			REG_PULSE_PER:  pulse_len = data;
			default: ;
		endcase
	endtask

	// full register set, only ever written with the block idle; unused
	// upper data bits carry junk and a stray index is written now and then
	task automatic write_settings(input int lo, input int ns, input int wend,
		input int tdiv, input int pper);
		drain_results();
		cfg_write(REG_LOW_THR,    {2'($urandom), 10'(lo)});
		cfg_write(REG_NOSIG_THR,  {2'($urandom), 10'(ns)});
		cfg_write(REG_WINDOW_END, {2'($urandom), 10'(wend)});
		cfg_write(REG_TONE_DIV,   {4'($urandom), 8'(tdiv)});
		cfg_write(REG_PULSE_PER,  12'(pper));
		if ($urandom_range(0, 1) != 0)
			cfg_write(3'(REG_PULSE_PER) + 3'($urandom_range(1, 3)), 12'($urandom));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// result side: random stalls and the field-by-field check
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (alarm_expected.size() == 0) begin
					errors++;
					$error("result with no sample owed");
				end else begin
					want = alarm_expected.pop_front();
					if (alarm_out !== want.alarm) begin
						errors++;
						$error("alarm_out: expected %0d, got %0d", want.alarm, alarm_out);
					end
					if (tone_out !== want.tone) begin
						errors++;
						$error("tone_out: expected %0d, got %0d", want.tone, tone_out);
					end
					if (alarm_mode !== want.mode) begin
						errors++;
						$error("alarm_mode: expected %0d, got %0d", want.mode, alarm_mode);
					end
					if (duty !== want.duty) begin
						errors++;
						$error("duty: expected %0d, got %0d", want.duty, duty);
					end
				end
			end
			result_ready <= ($urandom_range(0, 99) >= ready_idle_pct);
		end
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// nothing written yet: a strong signal over one default-length window
	// gives an average just above the default low threshold, pulsed mode
	task automatic test_reset_values();
		repeat (201)
			send_sample(10'($urandom_range(1000, 1023)));
	endtask

	// one-sample windows: average climbs through pulsed into continuous,
	// duty saturates, then falls back through pulsed to no alarm
	task automatic test_directed();
		write_settings(100, 600, 0, 1, 2);
		repeat (8)
			send_sample(10'h3FF);
		send_sample(10'h155);
		send_sample(10'h2AA);
		repeat (8)
			send_sample(10'h000);
		send_sample(10'h3FF);
	endtask

	// random settings per phase, short windows so the ring turns over often
	task automatic test_random_windows(input int phases, input int per_phase);
		int lo;
		int ns;
		int wend;
		int tdiv;
		int pper;
		repeat (phases) begin
			if ($urandom_range(0, 7) == 0)
				lo = ($urandom_range(0, 1) != 0) ? 1023 : 0;
			else
				lo = $urandom_range(0, 700);
			case ($urandom_range(0, 7))
				0: ns = ($urandom_range(0, 1) != 0) ? 1023 : 0;
				1: ns = $urandom_range(0, lo);      // no pulsed band at all
				default: ns = clamp_code(lo + int'($urandom_range(0, 300)));
			endcase
			wend = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
			case ($urandom_range(0, 9))
				0: tdiv = 0;
				1: tdiv = 255;
				default: tdiv = $urandom_range(1, 5);
			endcase
			case ($urandom_range(0, 9))
				0: pper = 0;
				1: pper = 4095;
				default: pper = $urandom_range(1, 8);
			endcase
			write_settings(lo, ns, wend, tdiv, pper);
			repeat (per_phase)
				send_sample(pick_sample());
		end
	endtask

	// continuous tone with a long divider, then the divider is zeroed while
	// the tick counter is well above it: ticks come only on the 8-bit wrap
	task automatic test_tone_divide_zero();
		write_settings(0, 0, 3, 200, 5);
		repeat (80)
			send_sample(10'($urandom_range(500, 1023)));
		write_settings(0, 0, 3, 0, 5);
		repeat (260)
			send_sample(10'($urandom_range(500, 1023)));
	endtask

	// longest window, largest divider and period; halfway through the
	// sender holds off until every owed result is back
	task automatic test_long_window();
		write_settings(0, 1023, 1023, 255, 4095);
		repeat (260)
			send_sample(pick_sample());
		drain_results();
		repeat (260)
			send_sample(pick_sample());
	endtask

	// window end lowered below the running sample count: the count has to
	// wrap at 10 bits before the next window can close
	task automatic test_counter_wrap();
		write_settings($urandom_range(0, 300), $urandom_range(300, 1023), 20, 2, 3);
		repeat (540)
			send_sample(pick_sample());
	endtask

	initial begin
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles now and then, receiver stalls mostly
		send_idle_pct  = 36;
		ready_idle_pct = 64;
		test_reset_values();
		test_directed();
		test_tone_divide_zero();
		test_random_windows(4, 20);

		// the other way round
		send_idle_pct  = 64;
		ready_idle_pct = 36;
		test_random_windows(4, 20);

		// full rate on both sides
		send_idle_pct  = 0;
		ready_idle_pct = 0;
		test_random_windows(4, 20);
		test_long_window();
		test_counter_wrap();

		drain_results();
		repeat (8)
			@(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
